>>> rtl/dfl_pkg.sv
// Shared constants, types and helper functions of the decimating FIR low-pass filter.
package dfl_pkg;

    localparam int MAX_ORDER     = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 18;
    localparam int GAIN_BITS     = 24;
    localparam int GAIN_FRAC     = 16;
    localparam int ORDER_BITS    = 9;
    localparam int DEC_BITS      = 8;
    localparam int WARM_BITS     = ORDER_BITS - 1;
    localparam int LINE_DEPTH    = MAX_ORDER + 1;
    localparam int ADDR_BITS     = $clog2(LINE_DEPTH);
    localparam int FILL_BITS     = $clog2(LINE_DEPTH + 1);
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS      = PROD_BITS + ADDR_BITS;
    localparam int MAG_LO        = ACC_BITS / 2;
    localparam int SUM_BITS      = ACC_BITS + GAIN_BITS + 1;
    localparam int OUT_SHIFT     = COEF_BITS - 1 + GAIN_FRAC;
    localparam int Q_BITS        = SUM_BITS - OUT_SHIFT;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECIMATION = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_INDEX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_VALUE = 3'd4;

    typedef struct packed {
        logic [ORDER_BITS-1:0] order;
        logic [WARM_BITS-1:0]  dly;
        logic [DEC_BITS-1:0]   dec;
        logic [GAIN_BITS-1:0]  gain;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
        logic                          emit;
    } t_item;

    typedef struct packed {
        logic                        we;
        logic [ORDER_BITS-1:0]       addr;
        logic signed [COEF_BITS-1:0] data;
    } t_coef_wr;

    function automatic logic [ORDER_BITS-1:0] eff_order(input logic [ORDER_BITS-1:0] fo);
        logic [ORDER_BITS-1:0] ord;
        ord = fo & ~ORDER_BITS'(1);
        if (ord < ORDER_BITS'(2)) ord = ORDER_BITS'(2);
        if (ord > ORDER_BITS'(MAX_ORDER)) ord = ORDER_BITS'(MAX_ORDER) & ~ORDER_BITS'(1);
        return ord;
    endfunction

    function automatic logic [DEC_BITS-1:0] eff_dec(input logic [DEC_BITS-1:0] d);
        return (d == '0) ? DEC_BITS'(1) : d;
    endfunction

endpackage

>>> rtl/decimating_fir_lowpass.sv
// Top level of the decimating FIR low-pass filter: configuration registers and wiring.
//
// One sample word is accepted per handshake into a two-word queue; the front end
// tags it for warm-up and decimation while the back end works. A word that yields
// no result only writes the delay line; one that yields a result runs the single
// shared multiply-accumulate, which reads one tap and one delay-line entry per cycle
// from two memories, followed by a two-step gain multiply, rounding and clipping.
// History is cleared by a fill count, so there is no clearing pass after reset or
// a start flag. Tap weights have no reset and must be loaded for every tap in use
// before streaming; configuration must be written only while the filter is idle
// (the user's duty: the block itself does not enforce it).
module decimating_fir_lowpass (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [15:0]                          i_s_axis_tdata,  // [15:0] sample
    input  logic [1:0]                           i_s_axis_tuser,  // [0] pad, [1] first
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [15:0]                          o_m_axis_tdata,  // [15:0] filtered
    output logic [0:0]                           o_m_axis_tuser,  // [0] saturated
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dfl_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [dfl_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [dfl_pkg::ORDER_BITS-1:0] r_filter_order;
    logic [dfl_pkg::DEC_BITS-1:0]   r_decimation;
    logic [dfl_pkg::GAIN_BITS-1:0]  r_gain;
    logic [dfl_pkg::ORDER_BITS-1:0] r_coef_index;

    dfl_pkg::t_cfg     cfg;
    dfl_pkg::t_coef_wr coef_wr;
    dfl_pkg::t_item    push_item, head_item;
    logic              cfg_we, push, pop, full, empty;
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] filtered;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_order <= dfl_pkg::ORDER_BITS'(2);
            r_decimation   <= dfl_pkg::DEC_BITS'(1);
            r_gain         <= dfl_pkg::GAIN_BITS'(65536);
            r_coef_index   <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                dfl_pkg::CFG_ORDER:      r_filter_order <= i_cfg_data[dfl_pkg::ORDER_BITS-1:0];
                dfl_pkg::CFG_DECIMATION: r_decimation   <= i_cfg_data[dfl_pkg::DEC_BITS-1:0];
                dfl_pkg::CFG_GAIN:       r_gain         <= i_cfg_data[dfl_pkg::GAIN_BITS-1:0];
                dfl_pkg::CFG_COEF_INDEX: r_coef_index   <= i_cfg_data[dfl_pkg::ORDER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.order    = dfl_pkg::eff_order(r_filter_order);
        cfg.dly      = cfg.order[dfl_pkg::ORDER_BITS-1:1];
        cfg.dec      = dfl_pkg::eff_dec(r_decimation);
        cfg.gain     = r_gain;
        coef_wr.we   = cfg_we && (i_cfg_index == dfl_pkg::CFG_COEF_VALUE);
        coef_wr.addr = r_coef_index;
        coef_wr.data = $signed(i_cfg_data[dfl_pkg::COEF_BITS-1:0]);
    end

    dfl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample ($signed(i_s_axis_tdata[dfl_pkg::SAMPLE_BITS-1:0])),
        .i_pad    (i_s_axis_tuser[0]),
        .i_first  (i_s_axis_tuser[1]),
        .i_cfg    (cfg),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    dfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    dfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .i_coef_wr   (coef_wr),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_filtered  (filtered),
        .o_saturated (o_m_axis_tuser[0])
    );

    assign o_m_axis_tdata = $unsigned(filtered);

endmodule

>>> rtl/dfl_front.sv
// Front end: accepts samples, tracks warm-up and decimation phase, tags each word.
module dfl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dfl_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                i_pad,
    input  logic                                i_first,
    input  dfl_pkg::t_cfg                       i_cfg,
    input  logic                                i_full,
    output logic                                o_push,
    output dfl_pkg::t_item                      o_item
);

    logic [dfl_pkg::WARM_BITS-1:0] r_warm, n_warm, w;
    logic [dfl_pkg::DEC_BITS-1:0]  r_phase, n_phase, p;
    logic                          emit;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w       = i_first ? '0 : r_warm;
        p       = i_first ? '0 : r_phase;
        n_warm  = w;
        n_phase = p;
        emit    = 1'b0;
        if (w < i_cfg.dly) begin
            n_warm = w + dfl_pkg::WARM_BITS'(1);
        end else begin
            emit = (p == '0);
            if (({1'b0, p} + 9'd1) >= {1'b0, i_cfg.dec}) begin
                n_phase = '0;
            end else begin
                n_phase = p + dfl_pkg::DEC_BITS'(1);
            end
        end
    end

    assign o_item.sample = i_pad ? '0 : i_sample;
    assign o_item.first  = i_first;
    assign o_item.emit   = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm  <= '0;
            r_phase <= '0;
        end else if (o_push) begin
            r_warm  <= n_warm;
            r_phase <= n_phase;
        end
    end

endmodule

>>> rtl/dfl_queue.sv
// Short FIFO of tagged words between the front and back ends.
module dfl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfl_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dfl_pkg::t_item o_item
);

    dfl_pkg::t_item                 r_mem [dfl_pkg::QUEUE_DEPTH];
    logic [dfl_pkg::QPTR_BITS-1:0]  r_wptr, r_rptr;
    logic [dfl_pkg::QCNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == dfl_pkg::QCNT_BITS'(dfl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == dfl_pkg::QPTR_BITS'(dfl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + dfl_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == dfl_pkg::QPTR_BITS'(dfl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + dfl_pkg::QPTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + dfl_pkg::QCNT_BITS'(1);
                2'b01:   r_count <= r_count - dfl_pkg::QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/dfl_back.sv
// Back end: delay line and tap memories, shared MAC, gain scaling and output register.
module dfl_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  dfl_pkg::t_item                       i_item,
    output logic                                 o_pop,
    input  dfl_pkg::t_cfg                        i_cfg,
    input  dfl_pkg::t_coef_wr                    i_coef_wr,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [dfl_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic                                 o_saturated
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RUN   = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_ABS   = 8'b0000_1000,
        S_MUL0  = 8'b0001_0000,
        S_MUL1  = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic signed [dfl_pkg::COEF_BITS-1:0]   r_coef_mem [dfl_pkg::LINE_DEPTH];
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] r_dly_mem  [dfl_pkg::LINE_DEPTH];

    logic [dfl_pkg::ADDR_BITS-1:0]   r_wp, r_k, r_daddr;
    logic [dfl_pkg::FILL_BITS-1:0]   r_fill;
    logic [dfl_pkg::ORDER_BITS-1:0]  r_off;
    logic                            r_rd_vld, r_rd_tap, r_pr_vld;
    logic signed [dfl_pkg::COEF_BITS-1:0]   r_coef_rd;
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] r_dly_rd;
    logic signed [dfl_pkg::PROD_BITS-1:0]   r_prod;
    logic signed [dfl_pkg::ACC_BITS-1:0]    r_acc;
    logic                                   r_neg;
    logic [dfl_pkg::ACC_BITS-1:0]           r_mag;
    logic [dfl_pkg::MAG_LO+dfl_pkg::GAIN_BITS-1:0] r_p0;
    logic [dfl_pkg::ACC_BITS-dfl_pkg::MAG_LO+dfl_pkg::GAIN_BITS-1:0] r_p1;
    logic [dfl_pkg::SUM_BITS-1:0]           r_sum;
    logic                                   r_out_vld, r_out_sat;
    logic signed [dfl_pkg::SAMPLE_BITS-1:0] r_out_data;

    logic [dfl_pkg::ADDR_BITS-1:0]   newest, wp_next, base;
    logic [dfl_pkg::ADDR_BITS:0]     base_sum;
    logic [dfl_pkg::FILL_BITS-1:0]   fill_base, n_fill;
    logic [dfl_pkg::Q_BITS-1:0]      q, lim, qc;
    logic                            sat, out_load;
    logic [dfl_pkg::SAMPLE_BITS-1:0] mag16;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        newest    = i_item.first ? '0 : r_wp;
        wp_next   = (newest == dfl_pkg::ADDR_BITS'(dfl_pkg::LINE_DEPTH - 1)) ?
                    '0 : newest + dfl_pkg::ADDR_BITS'(1);
        fill_base = i_item.first ? '0 : r_fill;
        n_fill    = (fill_base == dfl_pkg::FILL_BITS'(dfl_pkg::LINE_DEPTH)) ?
                    fill_base : fill_base + dfl_pkg::FILL_BITS'(1);
        base_sum  = {1'b0, newest} + (dfl_pkg::ADDR_BITS+1)'(dfl_pkg::LINE_DEPTH)
                    - (dfl_pkg::ADDR_BITS+1)'(i_cfg.order);
        base      = (base_sum >= (dfl_pkg::ADDR_BITS+1)'(dfl_pkg::LINE_DEPTH)) ?
                    dfl_pkg::ADDR_BITS'(base_sum - (dfl_pkg::ADDR_BITS+1)'(dfl_pkg::LINE_DEPTH)) :
                    base_sum[dfl_pkg::ADDR_BITS-1:0];
    end

    // rounding and clipping of the scaled magnitude
    always_comb begin
        q     = r_sum[dfl_pkg::SUM_BITS-1:dfl_pkg::OUT_SHIFT];
        lim   = r_neg ? dfl_pkg::Q_BITS'(2 ** (dfl_pkg::SAMPLE_BITS - 1)) :
                        dfl_pkg::Q_BITS'(2 ** (dfl_pkg::SAMPLE_BITS - 1) - 1);
        sat   = (q > lim);
        qc    = sat ? lim : q;
        mag16 = qc[dfl_pkg::SAMPLE_BITS-1:0];
    end

    assign out_load = (r_state == S_OUT) && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (i_coef_wr.we && (i_coef_wr.addr <= dfl_pkg::ORDER_BITS'(dfl_pkg::MAX_ORDER))) begin
            r_coef_mem[i_coef_wr.addr[dfl_pkg::ADDR_BITS-1:0]] <= i_coef_wr.data;
        end
        r_coef_rd <= r_coef_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dly_mem[newest] <= i_item.sample;
        end
        r_dly_rd <= r_dly_mem[r_daddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_rd_tap) begin
            r_prod <= r_coef_rd * r_dly_rd;
        end else begin
            r_prod <= '0;
        end
        if (o_pop) begin
            r_acc <= '0;
        end else if (r_pr_vld) begin
            r_acc <= r_acc + dfl_pkg::ACC_BITS'(r_prod);
        end
        if (r_state == S_RUN) begin
            r_rd_tap <= (r_off < r_fill);
        end
        if (r_state == S_ABS) begin
            r_neg <= r_acc[dfl_pkg::ACC_BITS-1];
            r_mag <= r_acc[dfl_pkg::ACC_BITS-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        end
        if (r_state == S_MUL0) begin
            r_p0 <= r_mag[dfl_pkg::MAG_LO-1:0] * i_cfg.gain;
        end
        if (r_state == S_MUL1) begin
            r_p1 <= r_mag[dfl_pkg::ACC_BITS-1:dfl_pkg::MAG_LO] * i_cfg.gain;
        end
        if (r_state == S_SUM) begin
            r_sum <= dfl_pkg::SUM_BITS'(r_p0)
                   + (dfl_pkg::SUM_BITS'(r_p1) << dfl_pkg::MAG_LO)
                   + (dfl_pkg::SUM_BITS'(1) << (dfl_pkg::OUT_SHIFT - 1));
        end
        if (out_load) begin
            r_out_data <= r_neg ? $signed(-mag16) : $signed(mag16);
            r_out_sat  <= sat;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_fill    <= '0;
            r_k       <= '0;
            r_daddr   <= '0;
            r_off     <= '0;
            r_rd_vld  <= 1'b0;
            r_pr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pr_vld <= r_rd_vld;
            r_rd_vld <= (r_state == S_RUN);
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_wp    <= wp_next;
                        r_fill  <= n_fill;
                        r_k     <= '0;
                        r_daddr <= base;
                        r_off   <= i_cfg.order;
                        if (i_item.emit) begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_k     <= r_k + dfl_pkg::ADDR_BITS'(1);
                    r_daddr <= (r_daddr == dfl_pkg::ADDR_BITS'(dfl_pkg::LINE_DEPTH - 1)) ?
                               '0 : r_daddr + dfl_pkg::ADDR_BITS'(1);
                    r_off   <= r_off - dfl_pkg::ORDER_BITS'(1);
                    if (dfl_pkg::ORDER_BITS'(r_k) == i_cfg.order) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !r_pr_vld) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS:  r_state <= S_MUL0;
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_SUM;
                S_SUM:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_vld;
    assign o_filtered  = r_out_data;
    assign o_saturated = r_out_sat;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dfl_pkg::FILL_BITS'(dfl_pkg::LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp < dfl_pkg::ADDR_BITS'(dfl_pkg::LINE_DEPTH)) &&
        (r_daddr < dfl_pkg::ADDR_BITS'(dfl_pkg::LINE_DEPTH)))
        else $error("delay line address out of range");

    a_mac_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ABS) |-> (!r_rd_vld && !r_pr_vld))
        else $error("scaling started before MAC pipeline drained");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out_data)))
        else $error("pending result overwritten");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> $past(r_state == S_IDLE || r_state == S_RUN))
        else $error("MAC run entered from unexpected state");

endmodule
